[hdl/tdss_pkg.sv]
// Shared types, codes and glyph lookup for the three-digit scan driver.
// No dependencies; every other file in hdl/ refers to this package by scope.
`timescale 1ns / 1ps

package tdss_pkg;

    // Display geometry
    localparam int NUM_DIGITS = 3;
    localparam int SCAN_W     = $clog2(NUM_DIGITS);
    localparam int CODE_W     = 5;
    localparam int SEG_W      = 8;

    // Command codes on the input channel
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_NUMBER = 2'd1;
    localparam logic [1:0] ACT_MODE   = 2'd2;

    // Message select for the set-mode command
    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_HI  = 2'd1;
    localparam logic [1:0] MODE_LO  = 2'd2;
    localparam logic [1:0] MODE_SET = 2'd3;

    // Result kinds on the output channel
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_SHIFT = 2'd1;
    localparam logic [1:0] KIND_LATCH = 2'd2;

    // Character codes; anything at or above GLYPH_COUNT is blank
    localparam logic [CODE_W-1:0] CHR_DASH   = 5'd10;
    localparam logic [CODE_W-1:0] CHR_H      = 5'd11;
    localparam logic [CODE_W-1:0] CHR_I      = 5'd12;
    localparam logic [CODE_W-1:0] CHR_L      = 5'd13;
    localparam logic [CODE_W-1:0] CHR_O      = 5'd14;
    localparam logic [CODE_W-1:0] CHR_E      = 5'd15;
    localparam logic [CODE_W-1:0] CHR_T      = 5'd16;
    localparam logic [CODE_W-1:0] CHR_R      = 5'd17;
    localparam logic [CODE_W-1:0] CHR_S      = 5'd5;
    localparam logic [CODE_W-1:0] CHR_BLANK  = 5'd31;
    localparam logic [CODE_W-1:0] GLYPH_COUNT = 5'd18;

    localparam logic [9:0] MAX_NUMBER = 10'd999;

    // Serializer step numbering: clear, eight data bits, latch
    localparam int          STEP_W     = 4;
    localparam logic [STEP_W-1:0] STEP_CLEAR = 4'd0;
    localparam logic [STEP_W-1:0] STEP_LATCH = 4'd9;

    typedef logic [CODE_W-1:0] t_code;

    typedef struct packed {
        logic [1:0] action;
        logic [9:0] number;
        logic [1:0] mode;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            kind;
        logic                  data_bit;
        logic [NUM_DIGITS-1:0] digit_enable;
        logic                  last;
    } t_out_item;

    // One queued tick: what the back end needs to play it out
    typedef struct packed {
        logic                  blank;
        logic [SEG_W-1:0]      pattern;
        logic [NUM_DIGITS-1:0] enable;
    } t_tick_desc;

    // Segment pattern per character code, shifted out LSB first
    function automatic logic [SEG_W-1:0] glyph(input t_code code);
        logic [SEG_W-1:0] pat;
        unique case (code)
            5'd0:    pat = 8'hE7;
            5'd1:    pat = 8'h84;
            5'd2:    pat = 8'hD3;
            5'd3:    pat = 8'hD5;
            5'd4:    pat = 8'hB4;
            5'd5:    pat = 8'h75;
            5'd6:    pat = 8'h77;
            5'd7:    pat = 8'hC4;
            5'd8:    pat = 8'hF7;
            5'd9:    pat = 8'hF5;
            5'd10:   pat = 8'h10;
            5'd11:   pat = 8'hB6;
            5'd12:   pat = 8'h02;
            5'd13:   pat = 8'h23;
            5'd14:   pat = 8'h17;
            5'd15:   pat = 8'h73;
            5'd16:   pat = 8'h33;
            5'd17:   pat = 8'h12;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

[hdl/tdss_front.sv]
// Front end: accepts commands, holds the display state, turns ticks into descriptors.
// Depends on tdss_pkg.
`timescale 1ns / 1ps

module tdss_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  tdss_pkg::t_in_item    i_in,
    input  logic                  i_full,
    output logic                  o_in_stall,
    output logic                  o_push,
    output tdss_pkg::t_tick_desc  o_desc
);

    tdss_pkg::t_code [tdss_pkg::NUM_DIGITS-1:0] r_codes, n_codes;
    logic [tdss_pkg::NUM_DIGITS-1:0] r_mask, n_mask;
    logic [tdss_pkg::SCAN_W-1:0]     r_scan, n_scan;

    logic        w_accept;
    logic [15:0] w_h_prod;
    logic [3:0]  w_hund;
    logic [9:0]  w_rem_full;
    logic [6:0]  w_rem;
    logic [14:0] w_t_prod;
    logic [3:0]  w_tens;
    logic [6:0]  w_ones_full;
    logic [3:0]  w_ones;
    tdss_pkg::t_code w_cur;

    assign o_in_stall = i_full;
    assign w_accept   = i_in_valid && !i_full;

    // Decimal split by reciprocal multiply: n*41>>12 is n/100 for n<1000,
    // r*205>>11 is r/10 for r<100
    assign w_h_prod    = (16'(i_in.number) << 5) + (16'(i_in.number) << 3) + 16'(i_in.number);
    assign w_hund      = w_h_prod[15:12];
    assign w_rem_full  = i_in.number - ((10'(w_hund) << 6) + (10'(w_hund) << 5)
                                        + (10'(w_hund) << 2));
    assign w_rem       = w_rem_full[6:0];
    assign w_t_prod    = (15'(w_rem) << 7) + (15'(w_rem) << 6) + (15'(w_rem) << 3)
                         + (15'(w_rem) << 2) + 15'(w_rem);
    assign w_tens      = w_t_prod[14:11];
    assign w_ones_full = w_rem - ((7'(w_tens) << 3) + (7'(w_tens) << 1));
    assign w_ones      = w_ones_full[3:0];

    // State update per command
    always_comb begin
        n_codes = r_codes;
        n_mask  = r_mask;
        n_scan  = r_scan;
        o_push  = 1'b0;
        if (w_accept) begin
            unique case (i_in.action)
                tdss_pkg::ACT_TICK: begin
                    o_push = 1'b1;
                    if (r_scan == tdss_pkg::SCAN_W'(tdss_pkg::NUM_DIGITS - 1)) begin
                        n_scan = '0;
                    end else begin
                        n_scan = r_scan + tdss_pkg::SCAN_W'(1);
                    end
                end
                tdss_pkg::ACT_NUMBER: begin
                    if (i_in.number <= tdss_pkg::MAX_NUMBER) begin
                        n_codes    = {tdss_pkg::NUM_DIGITS{tdss_pkg::CHR_BLANK}};
                        n_codes[2] = tdss_pkg::CODE_W'(w_ones);
                        if (i_in.number < 10'd10) begin
                            n_mask = 3'b100;
                        end else if (i_in.number < 10'd100) begin
                            n_codes[1] = tdss_pkg::CODE_W'(w_tens);
                            n_mask     = 3'b110;
                        end else begin
                            n_codes[1] = tdss_pkg::CODE_W'(w_tens);
                            n_codes[0] = tdss_pkg::CODE_W'(w_hund);
                            n_mask     = 3'b111;
                        end
                    end
                end
                tdss_pkg::ACT_MODE: begin
                    n_codes = {tdss_pkg::NUM_DIGITS{tdss_pkg::CHR_BLANK}};
                    unique case (i_in.mode)
                        tdss_pkg::MODE_HI: begin
                            n_codes[0] = tdss_pkg::CHR_H;
                            n_codes[1] = tdss_pkg::CHR_I;
                            n_mask     = 3'b011;
                        end
                        tdss_pkg::MODE_LO: begin
                            n_codes[0] = tdss_pkg::CHR_L;
                            n_codes[1] = tdss_pkg::CHR_O;
                            n_mask     = 3'b011;
                        end
                        tdss_pkg::MODE_SET: begin
                            n_codes[0] = tdss_pkg::CHR_S;
                            n_codes[1] = tdss_pkg::CHR_E;
                            n_codes[2] = tdss_pkg::CHR_T;
                            n_mask     = 3'b111;
                        end
                        default: begin
                            n_mask = '0;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // Descriptor for the digit under scan
    assign w_cur          = r_codes[r_scan];
    assign o_desc.blank   = (w_cur >= tdss_pkg::GLYPH_COUNT);
    assign o_desc.pattern = tdss_pkg::glyph(w_cur);
    assign o_desc.enable  = r_mask[r_scan]
                          ? (tdss_pkg::NUM_DIGITS'(1) << r_scan) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes <= '0;
            r_mask  <= '0;
            r_scan  <= '0;
        end else begin
            r_codes <= n_codes;
            r_mask  <= n_mask;
            r_scan  <= n_scan;
        end
    end

endmodule

[hdl/tdss_queue.sv]
// Two-entry queue of tick descriptors between front and back end.
// Depends on tdss_pkg.
`timescale 1ns / 1ps

module tdss_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  tdss_pkg::t_tick_desc  i_desc,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output tdss_pkg::t_tick_desc  o_head
);

    tdss_pkg::t_tick_desc r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_entry[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_desc;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hdl/tdss_back.sv]
// Back end: plays one tick descriptor out as pin-level results, one per cycle
// while the output is not stalled. Depends on tdss_pkg.
`timescale 1ns / 1ps

module tdss_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  tdss_pkg::t_tick_desc  i_head,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output tdss_pkg::t_out_item   o_out
);

    logic                         r_busy, n_busy;
    logic [tdss_pkg::STEP_W-1:0]  r_step, n_step;
    tdss_pkg::t_tick_desc         r_desc, n_desc;
    logic                         r_out_valid, n_out_valid;
    tdss_pkg::t_out_item          r_out, n_out;

    logic                         w_out_free;
    logic                         w_final;
    logic [tdss_pkg::STEP_W-1:0]  w_bit_idx;
    tdss_pkg::t_out_item          w_cur;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_final    = r_desc.blank ? (r_step == tdss_pkg::STEP_CLEAR)
                                     : (r_step == tdss_pkg::STEP_LATCH);
    assign w_bit_idx  = r_step - tdss_pkg::STEP_W'(1);

    // Result for the current step
    always_comb begin
        w_cur = '0;
        if (r_step == tdss_pkg::STEP_CLEAR) begin
            w_cur.kind = tdss_pkg::KIND_CLEAR;
            w_cur.last = r_desc.blank;
        end else if (r_step == tdss_pkg::STEP_LATCH) begin
            w_cur.kind         = tdss_pkg::KIND_LATCH;
            w_cur.digit_enable = r_desc.enable;
            w_cur.last         = 1'b1;
        end else begin
            w_cur.kind     = tdss_pkg::KIND_SHIFT;
            w_cur.data_bit = r_desc.pattern[w_bit_idx[2:0]];
        end
    end

    // Take the next descriptor when idle or when the current one finishes
    assign o_pop = !i_empty && (!r_busy || (w_out_free && w_final));

    always_comb begin
        n_busy      = r_busy;
        n_step      = r_step;
        n_desc      = r_desc;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_out_free) begin
            n_out_valid = r_busy;
            if (r_busy) begin
                n_out = w_cur;
                if (w_final) begin
                    n_busy = 1'b0;
                end else begin
                    n_step = r_step + tdss_pkg::STEP_W'(1);
                end
            end
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_step = tdss_pkg::STEP_CLEAR;
            n_desc = i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= tdss_pkg::STEP_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_desc <= n_desc;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // Latch pulse always closes a tick
    a_latch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.kind == tdss_pkg::KIND_LATCH) |-> r_out.last)
        else $error("latch result without last");

    // Digit drive only on a latch result, and at most one line
    a_enable_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.kind != tdss_pkg::KIND_LATCH) |-> (r_out.digit_enable == '0))
        else $error("digit enable outside latch");

    a_enable_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0(r_out.digit_enable))
        else $error("more than one digit enabled");

    // Never pop an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("pop from empty queue");

    // Step counter stays within a tick
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= tdss_pkg::STEP_LATCH))
        else $error("step counter out of range");
`endif

endmodule

[hdl/three_digit_seven_segment_scan_driver_top.sv]
// Top level of the three-digit seven-segment scan driver.
// Depends on tdss_pkg, tdss_front, tdss_queue and tdss_back.
`timescale 1ns / 1ps

// Drives a three-digit multiplexed display through a serial shift register.
// Set-number and set-mode commands produce no output transaction. A tick
// produces ten output transactions (clear enables, eight data bits LSB first,
// latch with the digit enable), or one for a blank digit; the serializer in
// the back end issues one result per cycle while the output is not stalled.
// A two-entry tick queue lets the input side keep accepting commands while
// results wait on the output stall, until the queue fills.

module three_digit_seven_segment_scan_driver_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tdss_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tdss_pkg::t_out_item  o_out
);

    logic                  w_push;
    logic                  w_pop;
    logic                  w_full;
    logic                  w_empty;
    tdss_pkg::t_tick_desc  w_desc;
    tdss_pkg::t_tick_desc  w_head;

    tdss_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_full     (w_full),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_desc     (w_desc)
    );

    tdss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_desc),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    tdss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
